@@ hdl/mbrot_pkg.sv @@
// Shared types, constants and fixed-point helpers of the Mandelbrot pixel evaluator.
package mbrot_pkg;

   localparam int Q_W               = 32;
   localparam int FRAC_BITS         = 24;
   localparam int PIX_W             = 10;
   localparam int ITER_W            = 16;
   localparam int COLOR_W           = 8;
   localparam int CSR_IDX_W         = 3;
   localparam int IMAGE_WIDTH_LOG2  = 10;
   localparam int IMAGE_HEIGHT_LOG2 = 10;

   // Pixel position times window span, both sign extended.
   localparam int PROD_W = PIX_W + Q_W + 2;
   // Working width for exact sums before saturation.
   localparam int WIDE_W = 48;

   localparam logic [Q_W:0] ESCAPE_LIMIT = (Q_W + 1)'(4) << FRAC_BITS;

   localparam logic signed [WIDE_W-1:0] Q_MAX_WIDE =
      {{(WIDE_W-Q_W+1){1'b0}}, {(Q_W-1){1'b1}}};
   localparam logic signed [WIDE_W-1:0] Q_MIN_WIDE =
      {{(WIDE_W-Q_W+1){1'b1}}, {(Q_W-1){1'b0}}};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_X_LEFT         = 3'd0,
      CSR_X_RIGHT        = 3'd1,
      CSR_Y_TOP          = 3'd2,
      CSR_Y_BOTTOM       = 3'd3,
      CSR_MAX_ITERATIONS = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic accept;
      logic map;
      logic iter_sum;
      logic iter_sq;
      logic out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic iter_done;
      logic out_free;
   } dp_status_type;

   // Clamp an exact sum to the signed Q8.24 range.
   function automatic logic signed [Q_W-1:0] sat_q(input logic signed [WIDE_W-1:0] v);
      if (v > Q_MAX_WIDE) begin
         return {1'b0, {(Q_W-1){1'b1}}};
      end else if (v < Q_MIN_WIDE) begin
         return {1'b1, {(Q_W-1){1'b0}}};
      end else begin
         return v[Q_W-1:0];
      end
   endfunction

   // Square in Q8.24, truncated, clamped to the positive maximum.
   function automatic logic [Q_W-1:0] square_q(input logic signed [Q_W-1:0] v);
      logic signed [2*Q_W-1:0] p;
      p = v * v;
      if (|p[2*Q_W-1:FRAC_BITS+Q_W-1]) begin
         return {1'b0, {(Q_W-1){1'b1}}};
      end else begin
         return {1'b0, p[FRAC_BITS+Q_W-2:FRAC_BITS]};
      end
   endfunction

endpackage

@@ hdl/mbrot_ctrl.sv @@
// Sequencer of the Mandelbrot pixel evaluator: mapping, iteration loop and result hand-off.
module mbrot_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  mbrot_pkg::dp_status_type status,
   output mbrot_pkg::dp_cmd_type    cmd
);
   import mbrot_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MAP,
      S_ITER_SUM,
      S_ITER_SQ,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      req_stall_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_MAP;
            end
         end
         S_MAP: begin
            cmd.map  = 1'b1;
            state_in = S_ITER_SUM;
         end
         S_ITER_SUM: begin
            // The loop test is made on the squares left by the previous step.
            if (status.iter_done) begin
               state_in = S_FINISH;
            end else begin
               cmd.iter_sum = 1'b1;
               state_in     = S_ITER_SQ;
            end
         end
         S_ITER_SQ: begin
            cmd.iter_sq = 1'b1;
            state_in    = S_ITER_SUM;
         end
         S_FINISH: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         req_stall_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_stall_ff <= (state_in != S_IDLE);
      end
   end

   assign req_stall = req_stall_ff;

   a_accept_then_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input taken but block did not go busy");

   a_sq_follows_sum: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ITER_SQ) |-> $past(state_ff == S_ITER_SUM))
      else $error("square phase entered without a sum phase");

   a_finish_to_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH && status.out_free) |=> (state_ff == S_IDLE && !req_stall))
      else $error("block did not return to idle after handing off a result");

endmodule

@@ hdl/mbrot_dp.sv @@
// Datapath of the Mandelbrot pixel evaluator: window mapping, iteration step and result register.
module mbrot_dp (
   input  logic                                     clock,
   input  logic                                     reset,
   input  mbrot_pkg::dp_cmd_type                    cmd,
   output mbrot_pkg::dp_status_type                 status,
   input  logic        [mbrot_pkg::PIX_W-1:0]       req_pixel_col,
   input  logic        [mbrot_pkg::PIX_W-1:0]       req_pixel_row,
   input  logic signed [mbrot_pkg::Q_W-1:0]         x_left,
   input  logic signed [mbrot_pkg::Q_W-1:0]         x_right,
   input  logic signed [mbrot_pkg::Q_W-1:0]         y_top,
   input  logic signed [mbrot_pkg::Q_W-1:0]         y_bottom,
   input  logic        [mbrot_pkg::ITER_W-1:0]      max_iterations,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic        [mbrot_pkg::ITER_W-1:0]      rsp_iterations,
   output logic                                     rsp_inside_res,
   output logic        [mbrot_pkg::COLOR_W-1:0]     rsp_red,
   output logic        [mbrot_pkg::COLOR_W-1:0]     rsp_green,
   output logic        [mbrot_pkg::COLOR_W-1:0]     rsp_blue
);
   import mbrot_pkg::*;

   logic signed [Q_W:0]        span_x, span_y;
   logic signed [PROD_W-1:0]   prod_x_in, prod_y_in, prod_x_ff, prod_y_ff;
   logic signed [PROD_W-1:0]   bias_x, bias_y, quot_x, quot_y;
   logic signed [WIDE_W-1:0]   sum_x, sum_y;
   logic signed [Q_W-1:0]      c_re_ff, c_im_ff;
   logic signed [Q_W-1:0]      x_in, y_in, s_in, x_ff, y_ff, s_ff;
   logic signed [WIDE_W-1:0]   x_raw, y_raw, s_raw;
   logic signed [WIDE_W-1:0]   x2_wide, y2_wide, w_wide;
   logic        [Q_W-1:0]      x2_ff, y2_ff, w_ff;
   logic        [ITER_W-1:0]   n_ff;
   logic        [Q_W:0]        mag;
   logic                       limit_hit;
   logic        [COLOR_W-1:0]  n_lo, green_mod;
   logic                       rsp_valid_ff;
   logic        [ITER_W-1:0]   rsp_iterations_ff;
   logic                       rsp_inside_ff;
   logic        [COLOR_W-1:0]  rsp_red_ff, rsp_green_ff, rsp_blue_ff;

   // Window mapping: position times span, then divide by the image size
   // rounding toward zero, then add the left or top edge.
   assign span_x    = $signed({x_right[Q_W-1], x_right}) - $signed({x_left[Q_W-1], x_left});
   assign span_y    = $signed({y_bottom[Q_W-1], y_bottom}) - $signed({y_top[Q_W-1], y_top});
   assign prod_x_in = $signed({1'b0, req_pixel_col}) * span_x;
   assign prod_y_in = $signed({1'b0, req_pixel_row}) * span_y;

   assign bias_x = prod_x_ff[PROD_W-1] ? PROD_W'((1 << IMAGE_WIDTH_LOG2) - 1) : '0;
   assign bias_y = prod_y_ff[PROD_W-1] ? PROD_W'((1 << IMAGE_HEIGHT_LOG2) - 1) : '0;
   assign quot_x = (prod_x_ff + bias_x) >>> IMAGE_WIDTH_LOG2;
   assign quot_y = (prod_y_ff + bias_y) >>> IMAGE_HEIGHT_LOG2;
   assign sum_x  = WIDE_W'(quot_x) + WIDE_W'(x_left);
   assign sum_y  = WIDE_W'(quot_y) + WIDE_W'(y_top);

   // Iteration step, first half: new x and y and their sum, each saturated once.
   assign x2_wide = WIDE_W'($signed({1'b0, x2_ff}));
   assign y2_wide = WIDE_W'($signed({1'b0, y2_ff}));
   assign w_wide  = WIDE_W'($signed({1'b0, w_ff}));
   assign x_raw   = x2_wide - y2_wide + WIDE_W'(c_re_ff);
   assign y_raw   = w_wide - x2_wide - y2_wide + WIDE_W'(c_im_ff);
   assign x_in    = sat_q(x_raw);
   assign y_in    = sat_q(y_raw);
   assign s_raw   = WIDE_W'(x_in) + WIDE_W'(y_in);
   assign s_in    = sat_q(s_raw);

   assign mag       = {1'b0, x2_ff} + {1'b0, y2_ff};
   assign limit_hit = (n_ff == max_iterations);

   assign status.iter_done = (mag > ESCAPE_LIMIT) || limit_hit;
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   assign n_lo      = n_ff[COLOR_W-1:0];
   assign green_mod = (n_lo << 3) - n_lo;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         prod_x_ff <= prod_x_in;
         prod_y_ff <= prod_y_in;
      end
      if (cmd.map) begin
         c_re_ff <= sat_q(sum_x);
         c_im_ff <= sat_q(sum_y);
         x2_ff   <= '0;
         y2_ff   <= '0;
         w_ff    <= '0;
         n_ff    <= '0;
      end
      if (cmd.iter_sum) begin
         x_ff <= x_in;
         y_ff <= y_in;
         s_ff <= s_in;
      end
      if (cmd.iter_sq) begin
         x2_ff <= square_q(x_ff);
         y2_ff <= square_q(y_ff);
         w_ff  <= square_q(s_ff);
         n_ff  <= n_ff + ITER_W'(1);
      end
      if (cmd.out_load) begin
         rsp_iterations_ff <= n_ff;
         rsp_inside_ff     <= limit_hit;
         rsp_red_ff        <= limit_hit ? '0 : n_lo;
         rsp_green_ff      <= limit_hit ? '0 : green_mod;
         rsp_blue_ff       <= limit_hit ? '0 : n_lo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_iterations = rsp_iterations_ff;
   assign rsp_inside_res = rsp_inside_ff;
   assign rsp_red        = rsp_red_ff;
   assign rsp_green      = rsp_green_ff;
   assign rsp_blue       = rsp_blue_ff;

   a_load_only_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result register overwritten while a stalled item waits");

   a_load_shows_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid_ff)
      else $error("loaded result not presented");

   a_loop_stops: assert property (@(posedge clock) disable iff (reset)
      cmd.iter_sum |-> !status.iter_done)
      else $error("iteration step taken after escape or limit");

endmodule

@@ hdl/mandelbrot_escape_time_pixel.sv @@
// Top level of the Mandelbrot escape-time pixel evaluator: register bank and unit wiring.
//
// One req item carries a pixel column and row. The block maps it into the
// complex window held in the csr registers (signed Q8.24) and runs the
// escape-time iteration until |z|^2 exceeds 4.0 or max_iterations is reached.
// One rsp item follows each req item: iteration count, inside flag and color.
// The csr port is a plain write port (csr_write_en, csr_index, csr_wdata); the
// user must write it only while the block is idle, the block does not enforce it.
// An accepted item passes through mapping, then for each iteration step a sum
// phase (the new x and y and their sum) and a square phase (the three squares),
// then the final test and the load of the result register, which waits while
// the register still holds a stalled result. The block holds one item at a time
// and takes no new item until it is back in idle.
// The result register lets the next item be accepted while an earlier result
// waits; a stalled rsp item holds, and a finished item waits in the block
// until the register is free, with req_stall high meanwhile.
// Synchronous reset returns the window and limit to their defaults, empties
// the result register and leaves the block idle, ready for an item.
module mandelbrot_escape_time_pixel (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic        [mbrot_pkg::PIX_W-1:0]     req_pixel_col,
   input  logic        [mbrot_pkg::PIX_W-1:0]     req_pixel_row,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic        [mbrot_pkg::ITER_W-1:0]    rsp_iterations,
   output logic                                   rsp_inside_res,
   output logic        [mbrot_pkg::COLOR_W-1:0]   rsp_red,
   output logic        [mbrot_pkg::COLOR_W-1:0]   rsp_green,
   output logic        [mbrot_pkg::COLOR_W-1:0]   rsp_blue,
   input  logic                                   csr_write_en,
   input  logic        [mbrot_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic        [mbrot_pkg::Q_W-1:0]       csr_wdata
);
   import mbrot_pkg::*;

   logic signed [Q_W-1:0]    x_left_ff, x_right_ff, y_top_ff, y_bottom_ff;
   logic        [ITER_W-1:0] max_iterations_ff;
   dp_cmd_type               cmd;
   dp_status_type            status;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_left_ff         <= Q_W'(-41943040);
         x_right_ff        <= Q_W'(16777216);
         y_top_ff          <= Q_W'(-16777216);
         y_bottom_ff       <= Q_W'(16777216);
         max_iterations_ff <= ITER_W'(256);
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_X_LEFT:         x_left_ff         <= csr_wdata;
            CSR_X_RIGHT:        x_right_ff        <= csr_wdata;
            CSR_Y_TOP:          y_top_ff          <= csr_wdata;
            CSR_Y_BOTTOM:       y_bottom_ff       <= csr_wdata;
            CSR_MAX_ITERATIONS: max_iterations_ff <= csr_wdata[ITER_W-1:0];
            default: begin
            end
         endcase
      end
   end

   mbrot_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   mbrot_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_pixel_col  (req_pixel_col),
      .req_pixel_row  (req_pixel_row),
      .x_left         (x_left_ff),
      .x_right        (x_right_ff),
      .y_top          (y_top_ff),
      .y_bottom       (y_bottom_ff),
      .max_iterations (max_iterations_ff),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_iterations (rsp_iterations),
      .rsp_inside_res (rsp_inside_res),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue)
   );

endmodule

@@ tb/mandelbrot_escape_time_pixel_test.sv @@
// Self-checking testbench for the Mandelbrot escape-time pixel evaluator.
module mandelbrot_escape_time_pixel_test;
   timeunit 1ns;
   timeprecision 1ps;
   import mbrot_pkg::*;

   localparam longint IMAGE_W     = 1024;
   localparam longint IMAGE_H     = 1024;
   localparam longint Q_HI        = 64'sd2147483647;
   localparam longint Q_LO        = -64'sd2147483648;
   localparam longint ESCAPE_Q    = 64'sd4 << FRAC_BITS;
   localparam int     STALL_LIMIT = 600_000;

   localparam logic [Q_W-1:0] Q_ONE  = 32'h0100_0000;
   localparam logic [Q_W-1:0] Q_TWO  = 32'h0200_0000;
   localparam logic [Q_W-1:0] Q_PMAX = 32'h7FFF_FFFF;
   localparam logic [Q_W-1:0] Q_NMAX = 32'h8000_0000;

   typedef struct {
      logic [PIX_W-1:0]   col;
      logic [PIX_W-1:0]   row;
      logic [ITER_W-1:0]  iterations;
      logic               in_set;
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } pixel_result_type;

   class escape_scoreboard;
      longint           x_left;
      longint           x_right;
      longint           y_top;
      longint           y_bottom;
      int unsigned      iter_limit;
      pixel_result_type expected_pixels[$];
      int               mismatches;
      int               pixels_seen;
      int               inside_seen;

      function new();
         x_left     = -41943040;
         x_right    = 16777216;
         y_top      = -16777216;
         y_bottom   = 16777216;
         iter_limit = 256;
      endfunction

      function void set_register(csr_index_type idx, logic [Q_W-1:0] data);
         case (idx)
            CSR_X_LEFT:         x_left = longint'($signed(data));
            CSR_X_RIGHT:        x_right = longint'($signed(data));
            CSR_Y_TOP:          y_top = longint'($signed(data));
            CSR_Y_BOTTOM:       y_bottom = longint'($signed(data));
            CSR_MAX_ITERATIONS: iter_limit = data[ITER_W-1:0];
            default: ;
         endcase
      endfunction

      function longint clamp_q(longint v);
         if (v > Q_HI) return Q_HI;
         if (v < Q_LO) return Q_LO;
         return v;
      endfunction

      // The square is never negative, so the shift only truncates.
      function longint square_fix(longint v);
         longint p;
         p = (v * v) >>> FRAC_BITS;
         return (p > Q_HI) ? Q_HI : p;
      endfunction

      function longint map_to_window(logic [PIX_W-1:0] pos, longint lo, longint hi,
                                     longint size);
         longint prod;
         prod = longint'(pos) * (hi - lo);
         return clamp_q(lo + prod / size);
      endfunction

      function pixel_result_type escape_pixel(logic [PIX_W-1:0] col,
                                              logic [PIX_W-1:0] row);
         longint           c_re, c_im, x, y, s, x2, y2, w;
         int unsigned      n;
         pixel_result_type r;
         c_re = map_to_window(col, x_left, x_right, IMAGE_W);
         c_im = map_to_window(row, y_top, y_bottom, IMAGE_H);
         x2 = 0;
         y2 = 0;
         w  = 0;
         n  = 0;
         while (x2 + y2 <= ESCAPE_Q && n < iter_limit) begin
            x  = clamp_q(x2 - y2 + c_re);
            y  = clamp_q(w - x2 - y2 + c_im);
            x2 = square_fix(x);
            y2 = square_fix(y);
            s  = clamp_q(x + y);
            w  = square_fix(s);
            n++;
         end
         r.col        = col;
         r.row        = row;
         r.iterations = n[ITER_W-1:0];
         r.in_set     = (n == iter_limit);
         r.red        = r.in_set ? '0 : n[COLOR_W-1:0];
         r.green      = r.in_set ? '0 : 8'(n * 7);
         r.blue       = r.in_set ? '0 : n[COLOR_W-1:0];
         return r;
      endfunction

      function void note_pixel(logic [PIX_W-1:0] col, logic [PIX_W-1:0] row);
         pixel_result_type r;
         r = escape_pixel(col, row);
         expected_pixels.push_back(r);
         pixels_seen++;
         if (r.in_set) inside_seen++;
      endfunction

      function int pending();
         return expected_pixels.size();
      endfunction

      function void flag(string what, logic [PIX_W-1:0] col, logic [PIX_W-1:0] row,
                         longint got, longint want);
         if (mismatches < 40) begin
            $display("MISMATCH %s at pixel (%0d,%0d): got %0d, want %0d",
                     what, col, row, got, want);
         end
         mismatches++;
      endfunction

      function void check_result(logic [ITER_W-1:0] iterations, logic in_set,
                                 logic [COLOR_W-1:0] red, logic [COLOR_W-1:0] green,
                                 logic [COLOR_W-1:0] blue);
         pixel_result_type want;
         if (expected_pixels.size() == 0) begin
            flag("result with no pixel pending", '0, '0, iterations, 0);
            return;
         end
         want = expected_pixels.pop_front();
         if (iterations !== want.iterations)
            flag("iterations", want.col, want.row, iterations, want.iterations);
         if (in_set !== want.in_set)
            flag("inside_res", want.col, want.row, in_set, want.in_set);
         if (red !== want.red)
            flag("red", want.col, want.row, red, want.red);
         if (green !== want.green)
            flag("green", want.col, want.row, green, want.green);
         if (blue !== want.blue)
            flag("blue", want.col, want.row, blue, want.blue);
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [PIX_W-1:0]     req_pixel_col = '0;
   logic [PIX_W-1:0]     req_pixel_row = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [ITER_W-1:0]    rsp_iterations;
   logic                 rsp_inside_res;
   logic [COLOR_W-1:0]   rsp_red;
   logic [COLOR_W-1:0]   rsp_green;
   logic [COLOR_W-1:0]   rsp_blue;
   logic                 csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_X_LEFT;
   logic [Q_W-1:0]       csr_wdata = '0;

   bit                   calm = 1'b0;
   int                   quiet_cycles = 0;
   int                   settings_used = 1;
   escape_scoreboard     sb = new();

   mandelbrot_escape_time_pixel dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_pixel_col  (req_pixel_col),
      .req_pixel_row  (req_pixel_row),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_iterations (rsp_iterations),
      .rsp_inside_res (rsp_inside_res),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < 8);
   end

   // Result checking and the watchdog on cycles without any accepted item.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            sb.check_result(rsp_iterations, rsp_inside_res, rsp_red, rsp_green, rsp_blue);
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Watchdog expired with %0d results outstanding", sb.pending());
            $display("Mismatches found");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   task automatic send_pixel(input logic [PIX_W-1:0] col, input logic [PIX_W-1:0] row);
      if (!calm && $urandom_range(99) < 8) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < 40);
      end
      req_valid     <= 1'b1;
      req_pixel_col <= col;
      req_pixel_row <= row;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_pixel(col, row);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(negedge clock);
      while (sb.pending() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [Q_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      sb.set_register(idx, data);
      @(negedge clock);
   endtask

   task automatic program_window(input logic [Q_W-1:0] xl, input logic [Q_W-1:0] xr,
                                 input logic [Q_W-1:0] yt, input logic [Q_W-1:0] yb,
                                 input logic [ITER_W-1:0] limit);
      write_reg(CSR_X_LEFT, xl);
      write_reg(CSR_X_RIGHT, xr);
      write_reg(CSR_Y_TOP, yt);
      write_reg(CSR_Y_BOTTOM, yb);
      write_reg(CSR_MAX_ITERATIONS, {16'h0, limit});
      csr_write_en <= 1'b0;
      @(negedge clock);
      settings_used++;
   endtask

   // A random window: a zoom somewhere near the set, or anything at all; phase 0 takes a fixed window instead.
   task automatic pick_setting(input int phase);
      int              center_re, center_im, half;
      logic [Q_W-1:0]  xl, xr, yt, yb;
      logic [ITER_W-1:0] limit;
      center_re = -33554432 + int'($urandom_range(0, 41943040));
      center_im = -20132659 + int'($urandom_range(0, 40265318));
      half      = 1 << $urandom_range(10, 25);
      xl = center_re - half;
      xr = center_re + half;
      yt = center_im - half;
      yb = center_im + half;
      if ($urandom_range(1) == 1) {xl, xr} = {xr, xl};
      if ($urandom_range(1) == 1) {yt, yb} = {yb, yt};
      if ($urandom_range(3) == 0) begin
         xl = $urandom();
         xr = $urandom();
         yt = $urandom();
         yb = $urandom();
      end
      case ($urandom_range(9))
         0:       limit = ITER_W'($urandom_range(65, 300));
         1:       limit = '0;
         default: limit = ITER_W'($urandom_range(1, 64));
      endcase
      if (phase == 0) begin
         program_window(32'hFD80_0000, Q_ONE, -Q_ONE, Q_ONE, 16'd256);
      end else begin
         program_window(xl, xr, yt, yb, limit);
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Window and limit as they come out of reset.
      send_pixel(10'd0, 10'd0);
      send_pixel(10'd1023, 10'd1023);
      send_pixel(10'd1023, 10'd0);
      send_pixel(10'd0, 10'd1023);
      send_pixel(10'd512, 10'd512);
      send_pixel(10'd768, 10'd512);
      send_pixel(10'h155, 10'h2AA);
      drain_results();

      // Widest window, running from one end of the range to the other, no steps at all.
      program_window(Q_NMAX, Q_PMAX, Q_PMAX, Q_NMAX, 16'd0);
      send_pixel(10'd0, 10'd0);
      send_pixel(10'd1023, 10'd1023);
      drain_results();

      // Same window at the highest limit: saturated squares and sums, and the
      // centre pixel maps just left of zero and never escapes.
      write_reg(CSR_MAX_ITERATIONS, 32'h0000_FFFF);
      csr_write_en <= 1'b0;
      @(negedge clock);
      send_pixel(10'd0, 10'd0);
      send_pixel(10'd1023, 10'd0);
      send_pixel(10'd0, 10'd1023);
      send_pixel(10'd1023, 10'd1023);
      send_pixel(10'd512, 10'd512);
      drain_results();

      // Reversed real axis on the real line: c = 2 sits exactly on the escape bound.
      program_window(Q_TWO, -Q_TWO, '0, '0, 16'd40);
      send_pixel(10'd0, 10'd0);
      send_pixel(10'd256, 10'd0);
      send_pixel(10'd512, 10'd0);
      send_pixel(10'd1023, 10'd0);
      drain_results();

      for (int phase = 0; phase < 6; phase++) begin
         calm = (phase == 2);
         pick_setting(phase);
         for (int k = 0; k < 75; k++) begin
            if (phase == 4 && k == 37) drain_results();
            send_pixel(PIX_W'($urandom_range(0, 1023)), PIX_W'($urandom_range(0, 1023)));
         end
         drain_results();
      end

      while (sb.pending() != 0) begin
         void'(sb.expected_pixels.pop_front());
         sb.flag("result never arrived", '0, '0, 0, 1);
      end
      $display("Ran %0d pixels (%0d inside the set) under %0d register settings.",
               sb.pixels_seen, sb.inside_seen, settings_used);
      $display("Limits from 0 to 65535, reversed and saturating windows, random stalls.");
      if (sb.mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
